>>> src/fsfc_pkg.sv
package fsfc_pkg;

  // widths of the frame and the conversion
  localparam int unsigned RawW    = 16;
  localparam int unsigned FlowW   = 25;
  localparam int unsigned QuotW   = 24;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // serial step counts: one quotient bit per cycle, crc over both data bytes
  localparam logic [CntW-1:0] DivSteps = CntW'(QuotW);
  localparam logic [CntW-1:0] CrcSteps = CntW'(RawW);

  // crc-8 parameters
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [7:0] CrcInit = 8'hFF;

  // register reset values
  localparam logic [15:0] OffsetRst = 16'd32000;
  localparam logic [15:0] ScaleRst  = 16'd140;

  typedef enum logic [1:0] {
    RC_OK  = 2'd0,
    RC_BUS = 2'd1,
    RC_CRC = 2'd2
  } res_code_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OFFSET = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_CRC_EN = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_t;

  localparam logic CMD_INIT  = 1'b0;
  localparam logic CMD_FRAME = 1'b1;

endpackage

>>> src/fsfc_in_if.sv
interface fsfc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       bus_ok;
  logic [7:0] flow_high;
  logic [7:0] flow_low;
  logic [7:0] crc_byte;

  modport source (output valid, cmd, bus_ok, flow_high, flow_low, crc_byte, input ready);
  modport sink   (input valid, cmd, bus_ok, flow_high, flow_low, crc_byte, output ready);
endinterface

>>> src/fsfc_out_if.sv
interface fsfc_out_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               result_code;
  logic signed [24:0]       flow_value;
  logic                     crc_error_seen;
  logic                     status_ok;

  modport source (output valid, result_code, flow_value, crc_error_seen, status_ok,
                  input ready);
  modport sink   (input valid, result_code, flow_value, crc_error_seen, status_ok,
                  output ready);
endinterface

>>> src/flow_sensor_frame_checker_top.sv
// flow frame: the divider runs in ST_RUN, then ST_DONE commits the result to
// the output register once free; init or failed-bus request: ST_IDLE to ST_DONE
// a new request is taken only in ST_IDLE; frames are paced by the bit-serial
// restoring divider (24 quotient bits, one per cycle; crc bit-serial alongside)
// synchronous active-low reset: flow 0, flags cleared, registers to their defaults
module flow_sensor_frame_checker_top (
  input  logic                            clk,
  input  logic                            rst_n,
  fsfc_in_if.sink                         in_chan,
  fsfc_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [fsfc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [fsfc_pkg::CfgDatW-1:0]    cfg_wdata
);

  // configuration registers
  logic [15:0] offset_r;
  logic [15:0] scale_r;
  logic        crc_en_r;

  // control
  fsfc_pkg::state_t          state_r, state_nxt;
  logic [fsfc_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                      in_fire, out_free, commit, load_run;

  // request snapshot
  logic       cmd_r;
  logic       bus_ok_r;
  logic [7:0] crc_byte_r;
  logic       neg_r;

  // serial datapath
  logic [15:0]                div_r;
  logic [15:0]                rem_r, rem_nxt;
  logic [fsfc_pkg::QuotW-1:0] dvd_r, dvd_nxt;
  logic [15:0]                crc_data_r, crc_data_nxt;
  logic [7:0]                 crc_r, crc_nxt;

  // block state
  logic signed [fsfc_pkg::FlowW-1:0] flow_r, flow_nxt;
  logic                              err_r, err_nxt;
  logic                              init_r, init_nxt;
  fsfc_pkg::res_code_t               code_nxt;

  // output register
  logic                              out_valid_r;
  fsfc_pkg::res_code_t               out_code_r;
  logic signed [fsfc_pkg::FlowW-1:0] out_flow_r;
  logic                              out_err_r;
  logic                              out_stat_r;

  // load values
  logic [16:0] diff;
  logic [15:0] mag;
  logic [16:0] trial, sub;
  logic        fb;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= fsfc_pkg::OffsetRst;
      scale_r  <= fsfc_pkg::ScaleRst;
      crc_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (fsfc_pkg::cfg_idx_t'(cfg_index))
        fsfc_pkg::CFG_OFFSET: offset_r <= cfg_wdata[15:0];
        fsfc_pkg::CFG_SCALE:  scale_r  <= cfg_wdata[15:0];
        fsfc_pkg::CFG_CRC_EN: crc_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fsfc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = (in_chan.cmd == fsfc_pkg::CMD_FRAME && in_chan.bus_ok)
                      ? fsfc_pkg::ST_RUN : fsfc_pkg::ST_DONE;
        end
      end
      fsfc_pkg::ST_RUN: begin
        if (cnt_r == fsfc_pkg::DivSteps - 1'b1) state_nxt = fsfc_pkg::ST_DONE;
      end
      fsfc_pkg::ST_DONE: begin
        if (out_free) state_nxt = fsfc_pkg::ST_IDLE;
      end
      default: state_nxt = fsfc_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_chan.ready = 1'b0;
    commit        = 1'b0;
    load_run      = 1'b0;
    cnt_nxt       = cnt_r;
    unique case (state_r)
      fsfc_pkg::ST_IDLE: begin
        in_chan.ready = 1'b1;
        load_run      = in_chan.valid;
        cnt_nxt       = '0;
      end
      fsfc_pkg::ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
      end
      fsfc_pkg::ST_DONE: begin
        commit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fsfc_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // magnitude of raw minus offset, sign kept aside for truncation toward zero
  assign diff = {1'b0, in_chan.flow_high, in_chan.flow_low} - {1'b0, offset_r};
  assign mag  = diff[16] ? 16'(-diff) : diff[15:0];

  // one restoring division step
  assign trial = {rem_r, dvd_r[fsfc_pkg::QuotW-1]};
  assign sub   = trial - {1'b0, div_r};

  // one crc step, msb first
  assign fb = crc_r[7] ^ crc_data_r[15];

  always_comb begin
    rem_nxt      = rem_r;
    dvd_nxt      = dvd_r;
    crc_data_nxt = crc_data_r;
    crc_nxt      = crc_r;
    if (load_run) begin
      rem_nxt      = '0;
      dvd_nxt      = {mag, 8'h00};
      crc_data_nxt = {in_chan.flow_high, in_chan.flow_low};
      crc_nxt      = fsfc_pkg::CrcInit;
    end else if (state_r == fsfc_pkg::ST_RUN) begin
      if (!sub[16]) begin
        rem_nxt = sub[15:0];
        dvd_nxt = {dvd_r[fsfc_pkg::QuotW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        dvd_nxt = {dvd_r[fsfc_pkg::QuotW-2:0], 1'b0};
      end
      if (cnt_r < fsfc_pkg::CrcSteps) begin
        crc_data_nxt = {crc_data_r[14:0], 1'b0};
        crc_nxt      = {crc_r[6:0], 1'b0} ^ (fb ? fsfc_pkg::CrcPoly : 8'h00);
      end
    end
  end

  // datapath and request snapshot
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    dvd_r      <= dvd_nxt;
    crc_data_r <= crc_data_nxt;
    crc_r      <= crc_nxt;
    if (in_fire) begin
      cmd_r      <= in_chan.cmd;
      bus_ok_r   <= in_chan.bus_ok;
      crc_byte_r <= in_chan.crc_byte;
      neg_r      <= diff[16];
      div_r      <= (scale_r == 16'd0) ? 16'd1 : scale_r;
    end
  end

  // result of the finished request
  always_comb begin
    flow_nxt = flow_r;
    err_nxt  = err_r;
    init_nxt = init_r;
    code_nxt = fsfc_pkg::RC_OK;
    if (cmd_r == fsfc_pkg::CMD_INIT) begin
      flow_nxt = '0;
      err_nxt  = 1'b0;
      if (bus_ok_r) init_nxt = 1'b1;
      else          code_nxt = fsfc_pkg::RC_BUS;
    end else if (!bus_ok_r) begin
      code_nxt = fsfc_pkg::RC_BUS;
    end else begin
      flow_nxt = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
      if (crc_en_r && (crc_r != crc_byte_r)) begin
        err_nxt  = 1'b1;
        code_nxt = fsfc_pkg::RC_CRC;
      end
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flow_r <= '0;
      err_r  <= 1'b0;
      init_r <= 1'b0;
    end else if (commit) begin
      flow_r <= flow_nxt;
      err_r  <= err_nxt;
      init_r <= init_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_code_r <= code_nxt;
      out_flow_r <= flow_nxt;
      out_err_r  <= err_nxt;
      out_stat_r <= init_nxt && !err_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_code    = out_code_r;
  assign out_chan.flow_value     = out_flow_r;
  assign out_chan.crc_error_seen = out_err_r;
  assign out_chan.status_ok      = out_stat_r;

  // checks
  a_frame_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.cmd == fsfc_pkg::CMD_FRAME && in_chan.bus_ok
    |=> state_r == fsfc_pkg::ST_RUN)
    else $error("good frame did not start the divider");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fsfc_pkg::ST_RUN |-> cnt_r < fsfc_pkg::DivSteps)
    else $error("divider step count out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == fsfc_pkg::ST_DONE))
    else $error("result shown without a finished request");

  a_status_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_stat_r && out_err_r))
    else $error("status ok while crc error recorded");

endmodule

>>> dv/flow_sensor_frame_checker_top_tb.sv
module flow_sensor_frame_checker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic       cmd;
    logic       bus_ok;
    logic [7:0] flow_high;
    logic [7:0] flow_low;
    logic [7:0] crc_byte;
  } sensor_req_t;

  typedef struct {
    logic [1:0]         code;
    logic signed [24:0] flow;
    logic               crc_err;
    logic               status_ok;
  } flow_reading_t;

  // tracks sensor state and holds the readings each request should produce
  class flow_reading_board;
    int                 offset_reg;
    int                 scale_reg;
    bit                 crc_check_on;
    logic signed [24:0] flow_q8;
    bit                 crc_fault;
    bit                 init_done;
    flow_reading_t      readings_due[$];
    int                 mismatches;
    int                 checked;

    function new();
      offset_reg   = fsfc_pkg::OffsetRst;
      scale_reg    = fsfc_pkg::ScaleRst;
      crc_check_on = 1'b1;
      flow_q8      = '0;
      crc_fault    = 1'b0;
      init_done    = 1'b0;
      mismatches   = 0;
      checked      = 0;
    endfunction

    // crc-8, msb first, over the two data bytes
    static function logic [7:0] crc_of(logic [7:0] hi, logic [7:0] lo);
      logic [7:0]  crc;
      logic [15:0] word;
      crc  = fsfc_pkg::CrcInit;
      word = {hi, lo};
      for (int i = 15; i >= 0; i--) begin
        if (crc[7] ^ word[i]) crc = {crc[6:0], 1'b0} ^ fsfc_pkg::CrcPoly;
        else crc = {crc[6:0], 1'b0};
      end
      return crc;
    endfunction

    function void set_register(fsfc_pkg::cfg_idx_t idx,
                               logic [fsfc_pkg::CfgDatW-1:0] value);
      case (idx)
        fsfc_pkg::CFG_OFFSET: offset_reg = value;
        fsfc_pkg::CFG_SCALE:  scale_reg = value;
        fsfc_pkg::CFG_CRC_EN: crc_check_on = value[0];
        default: ;
      endcase
    endfunction

    // update the sensor state for one accepted request
    function void take_request(sensor_req_t req);
      flow_reading_t want;
      int            raw_word;
      int            divisor;
      want.code = fsfc_pkg::RC_OK;
      if (req.cmd == fsfc_pkg::CMD_INIT) begin
        flow_q8   = '0;
        crc_fault = 1'b0;
        if (req.bus_ok) init_done = 1'b1;
        else want.code = fsfc_pkg::RC_BUS;
      end else if (!req.bus_ok) begin
        want.code = fsfc_pkg::RC_BUS;
      end else begin
        raw_word = {req.flow_high, req.flow_low};
        divisor  = (scale_reg == 0) ? 1 : scale_reg;
        // signed int division truncates toward zero
        flow_q8  = 25'((raw_word - offset_reg) * 256 / divisor);
        if (crc_check_on && crc_of(req.flow_high, req.flow_low) != req.crc_byte) begin
          crc_fault = 1'b1;
          want.code = fsfc_pkg::RC_CRC;
        end
      end
      want.flow      = flow_q8;
      want.crc_err   = crc_fault;
      want.status_ok = init_done && !crc_fault;
      readings_due.push_back(want);
    endfunction

    function void check_reading(flow_reading_t got);
      flow_reading_t want;
      if (readings_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading with none pending: code %0d flow %0d crc_err %0b ok %0b",
                   got.code, got.flow, got.crc_err, got.status_ok);
        return;
      end
      want = readings_due.pop_front();
      checked++;
      if (got.code !== want.code || got.flow !== want.flow ||
          got.crc_err !== want.crc_err || got.status_ok !== want.status_ok) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reading %0d: want code %0d flow %0d crc_err %0b ok %0b,",
                   checked, want.code, want.flow, want.crc_err, want.status_ok,
                   " got code %0d flow %0d crc_err %0b ok %0b",
                   got.code, got.flow, got.crc_err, got.status_ok);
      end
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  localparam int QuietLimit    = 2000;
  localparam int RandomPhases  = 10;
  localparam int ItemsPerPhase = 53;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  fsfc_pkg::cfg_idx_t            cfg_index;
  logic [fsfc_pkg::CfgDatW-1:0]  cfg_wdata;

  fsfc_in_if  in_chan();
  fsfc_out_if out_chan();

  flow_reading_board board = new();

  bit burst_mode;
  int quiet_cycles = 0;
  int n_inits;
  int n_frames;
  int n_settings;

  flow_sensor_frame_checker_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycles since the last handshake on either channel
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("no handshake for %0d cycles", QuietLimit);
    $display("Verification failed");
    $finish;
  end

  // result side: random back-pressure, check every reading taken
  initial begin
    int            stall;
    flow_reading_t seen;
    out_chan.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid === 1'b1 && out_chan.ready === 1'b1));
      seen.code      = out_chan.result_code;
      seen.flow      = out_chan.flow_value;
      seen.crc_err   = out_chan.crc_error_seen;
      seen.status_ok = out_chan.status_ok;
      board.check_reading(seen);
    end
  end

  // one request with a random lead-in gap
  task automatic send_request(sensor_req_t req);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.cmd       <= req.cmd;
    in_chan.bus_ok    <= req.bus_ok;
    in_chan.flow_high <= req.flow_high;
    in_chan.flow_low  <= req.flow_low;
    in_chan.crc_byte  <= req.crc_byte;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    board.take_request(req);
    if (req.cmd == fsfc_pkg::CMD_INIT) n_inits++;
    else n_frames++;
  endtask

  // wait until every pending reading has come back
  task automatic drain_readings();
    in_chan.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all three registers, one per cycle
  task automatic apply_settings(logic [15:0] offset, logic [15:0] scale, logic crc_on);
    cfg_we    <= 1'b1;
    cfg_index <= fsfc_pkg::CFG_OFFSET;
    cfg_wdata <= offset;
    @(posedge clk);
    cfg_index <= fsfc_pkg::CFG_SCALE;
    cfg_wdata <= scale;
    @(posedge clk);
    cfg_index <= fsfc_pkg::CFG_CRC_EN;
    cfg_wdata <= fsfc_pkg::CfgDatW'(crc_on);
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_index <= fsfc_pkg::CFG_NONE;
    board.set_register(fsfc_pkg::CFG_OFFSET, offset);
    board.set_register(fsfc_pkg::CFG_SCALE, scale);
    board.set_register(fsfc_pkg::CFG_CRC_EN, fsfc_pkg::CfgDatW'(crc_on));
    n_settings++;
  endtask

  function automatic sensor_req_t frame_req(logic [7:0] hi, logic [7:0] lo, bit good_crc,
                                            logic bus_ok = 1'b1);
    sensor_req_t req;
    req.cmd       = fsfc_pkg::CMD_FRAME;
    req.bus_ok    = bus_ok;
    req.flow_high = hi;
    req.flow_low  = lo;
    req.crc_byte  = flow_reading_board::crc_of(hi, lo) ^ (good_crc ? 8'h00 : 8'h5A);
    return req;
  endfunction

  function automatic sensor_req_t init_req(logic bus_ok, logic [7:0] junk);
    sensor_req_t req;
    req.cmd       = fsfc_pkg::CMD_INIT;
    req.bus_ok    = bus_ok;
    req.flow_high = junk;
    req.flow_low  = ~junk;
    req.crc_byte  = junk;
    return req;
  endfunction

  // mostly well-formed frames, some bad crc, bus failures and inits
  function automatic sensor_req_t random_request(int offset);
    sensor_req_t req;
    int          pick;
    logic [15:0] raw;
    raw  = $urandom_range(0, 65535);
    pick = $urandom_range(0, 99);
    if (pick < 10) raw = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else if (pick < 35) raw = 16'(offset + $urandom_range(0, 512) - 256);
    req  = frame_req(raw[15:8], raw[7:0], 1'b1);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      req = init_req($urandom_range(0, 3) != 0, 8'($urandom));
    end else if (pick < 16) begin
      req.bus_ok = 1'b0;
      if ($urandom_range(0, 1)) req.crc_byte = 8'($urandom);
    end else if (pick < 32) begin
      req.crc_byte = req.crc_byte ^ 8'($urandom_range(1, 255));
    end
    return req;
  endfunction

  // main sequence
  initial begin
    logic [15:0] offset;
    logic [15:0] scale;
    logic        crc_on;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= fsfc_pkg::CFG_NONE;
    cfg_wdata         <= '0;
    in_chan.valid     <= 1'b0;
    in_chan.cmd       <= fsfc_pkg::CMD_INIT;
    in_chan.bus_ok    <= 1'b0;
    in_chan.flow_high <= '0;
    in_chan.flow_low  <= '0;
    in_chan.crc_byte  <= '0;
    burst_mode = 1'b0;
    n_inits    = 0;
    n_frames   = 0;
    n_settings = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, frame before init, failed inits, sticky error
    send_request(frame_req(8'h12, 8'h34, 1'b1));
    send_request(init_req(1'b0, 8'h00));
    send_request(frame_req(8'h40, 8'h00, 1'b1, 1'b0));
    send_request(init_req(1'b1, 8'hFF));
    send_request(frame_req(8'h00, 8'h00, 1'b1));
    send_request(frame_req(8'hFF, 8'hFF, 1'b1));
    send_request(frame_req(8'h7D, 8'h00, 1'b1));
    send_request(frame_req(8'h80, 8'h01, 1'b0));
    send_request(frame_req(8'h55, 8'hAA, 1'b1));
    send_request(frame_req(8'h01, 8'h02, 1'b0, 1'b0));
    send_request(init_req(1'b0, 8'hA5));
    send_request(frame_req(8'h7C, 8'hFF, 1'b0));
    send_request(init_req(1'b1, 8'h3C));

    // directed: crc check off, largest positive flow
    drain_readings();
    apply_settings(16'd0, 16'd1, 1'b0);
    send_request(frame_req(8'hFF, 8'hFF, 1'b1));
    send_request(frame_req(8'hAB, 8'hCD, 1'b0));
    send_request(frame_req(8'h00, 8'h01, 1'b1));

    // directed: zero scale, most negative flow
    drain_readings();
    apply_settings(16'hFFFF, 16'd0, 1'b1);
    send_request(frame_req(8'h00, 8'h00, 1'b1));
    send_request(frame_req(8'hFF, 8'hFF, 1'b1));
    send_request(frame_req(8'h12, 8'h00, 1'b0));

    // directed: largest scale
    drain_readings();
    apply_settings(16'd1234, 16'hFFFF, 1'b1);
    send_request(frame_req(8'hFF, 8'hFF, 1'b1));
    send_request(frame_req(8'h00, 8'h00, 1'b1));
    send_request(init_req(1'b1, 8'h00));

    // random phases under several register settings
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: begin
          offset = fsfc_pkg::OffsetRst;
          scale  = fsfc_pkg::ScaleRst;
          crc_on = 1'b1;
        end
        1: begin offset = 16'd0;     scale = 16'd1;    crc_on = 1'b1; end
        2: begin offset = 16'hFFFF;  scale = 16'hFFFF; crc_on = 1'b0; end
        3: begin offset = 16'hFFFF;  scale = 16'd0;    crc_on = 1'b1; end
        4: begin offset = 16'd0;     scale = 16'hFFFF; crc_on = 1'b1; end
        default: begin
          offset = $urandom_range(0, 65535);
          scale  = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 300))
                                               : 16'($urandom_range(1, 65535));
          crc_on = ($urandom_range(0, 3) != 0);
        end
      endcase
      drain_readings();
      apply_settings(offset, scale, crc_on);
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (i % 20 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        send_request(random_request(offset));
      end
      burst_mode = 1'b0;
    end

    drain_readings();
    repeat (30) @(posedge clk);

    $display("sent %0d requests (%0d inits, %0d frames) across %0d register settings",
             n_inits + n_frames, n_inits, n_frames, n_settings);
    $display("checked %0d readings, %0d mismatches", board.checked, board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
